### rtl/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Holds header constants and the result struct; no dependencies.
`default_nettype none

package lpmd_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned LENGTH_BYTES = 4;
    localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

    typedef struct packed {
        logic        valid;
        logic [7:0]  payload_byte;
        logic [31:0] message_id;
        logic        first_of_message;
        logic        last_of_message;
        logic        empty_message;
    } t_result;

endpackage

`default_nettype wire

### rtl/lpmd_parser.sv
// Header/payload parser: holds the framing state and decodes one byte.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_advance,
    input  wire logic [7:0]       i_byte,
    output lpmd_pkg::t_result     o_res
);
    import lpmd_pkg::*;

    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [31:0]          r_length, n_length;
    logic [31:0]          r_id, n_id;
    logic [31:0]          r_left, n_left;
    logic                 r_in_payload, n_in_payload;
    logic                 r_started, n_started;

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_length     = r_length;
        n_id         = r_id;
        n_left       = r_left;
        n_in_payload = r_in_payload;
        n_started    = r_started;
        o_res        = '0;

        if (r_in_payload) begin
            o_res.valid            = 1'b1;
            o_res.payload_byte     = i_byte;
            o_res.message_id       = r_id;
            o_res.first_of_message = !r_started;
            o_res.last_of_message  = (r_left <= 32'd1);
            o_res.empty_message    = 1'b0;
            n_left                 = r_left - 32'd1;
            n_started              = 1'b1;
            if (r_left <= 32'd1) begin
                n_in_payload = 1'b0;
                n_started    = 1'b0;
                n_left       = '0;
            end
        end else begin
            // write the byte into its lane of length or id
            for (int k = 0; k < LENGTH_BYTES; k++) begin
                if (r_hdr_idx[1:0] == 2'(k)) begin
                    if (r_hdr_idx < HDR_IDX_W'(LENGTH_BYTES)) begin
                        n_length[8*k +: 8] = i_byte;
                    end else begin
                        n_id[8*k +: 8] = i_byte;
                    end
                end
            end
            if (r_hdr_idx != HDR_LAST) begin
                n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
            end else begin
                n_hdr_idx = '0;
                if (r_length == 32'd0) begin
                    o_res.valid            = 1'b1;
                    o_res.payload_byte     = 8'd0;
                    o_res.message_id       = n_id;
                    o_res.first_of_message = 1'b1;
                    o_res.last_of_message  = 1'b1;
                    o_res.empty_message    = 1'b1;
                end else begin
                    n_left       = r_length;
                    n_in_payload = 1'b1;
                    n_started    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= '0;
            r_length     <= '0;
            r_id         <= '0;
            r_left       <= '0;
            r_in_payload <= 1'b0;
            r_started    <= 1'b0;
        end else if (i_advance) begin
            r_hdr_idx    <= n_hdr_idx;
            r_length     <= n_length;
            r_id         <= n_id;
            r_left       <= n_left;
            r_in_payload <= n_in_payload;
            r_started    <= n_started;
        end
    end

`ifndef ASSERT_OFF
    a_payload_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_idx == '0))
        else $error("header index not cleared during payload");

    a_enter_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !r_in_payload && r_hdr_idx == HDR_LAST && r_length != 32'd0)
        |=> r_in_payload)
        else $error("nonzero length header did not enter payload");

    a_leave_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && r_in_payload && r_left <= 32'd1) |=> !r_in_payload)
        else $error("payload did not end on last byte");
`endif

endmodule

`default_nettype wire

### rtl/lpmd_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire lpmd_pkg::t_result i_res,
    input  wire logic              i_stall,
    output logic                   o_blocked,
    output lpmd_pkg::t_result      o_res
);
    import lpmd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // slot is blocked while a result waits and the consumer stalls
    assign o_blocked = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_blocked) begin
            r_valid <= i_take && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_blocked && i_take && i_res.valid) begin
            r_res <= i_res;
        end
    end

    always_comb begin
        o_res       = r_res;
        o_res.valid = r_valid;
    end

`ifndef ASSERT_OFF
    a_empty_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.empty_message) |->
        (r_res.first_of_message && r_res.last_of_message && r_res.payload_byte == 8'd0))
        else $error("empty result lacks first/last marks or zero byte");
`endif

endmodule

`default_nettype wire

### rtl/length_prefixed_message_deframer_core.sv
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg, lpmd_parser and lpmd_out_stage.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------
//  in      | consumer  | i_valid / o_stall | i_in_byte
//  out     | producer  | o_valid / i_stall | o_payload_byte, o_message_id,
//          |           |                   | o_first_of_message, o_last_of_message,
//          |           |                   | o_empty_message
//
// One byte is accepted per clock while o_stall is low. A byte waits in the input
// register while the parser decodes it; any result then loads into the result
// register, where the consumer can take it.
// Reset (synchronous, active low) clears the framing state: the block then
// expects the first header byte.
// A stall on the output holds the result register; the input register holds
// its byte and o_stall rises only while that byte cannot move on.
`default_nettype none

module length_prefixed_message_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_payload_byte,
    output logic [31:0]      o_message_id,
    output logic             o_first_of_message,
    output logic             o_last_of_message,
    output logic             o_empty_message
);
    import lpmd_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       w_blocked;
    logic       w_move;
    t_result    w_res;
    t_result    w_out;

    // advance the held byte whenever the result slot can take it
    assign w_move  = r_s1_valid && !w_blocked;
    // hold the input request only while a byte is stuck in stage one
    assign o_stall = r_s1_valid && w_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_s1_byte <= i_in_byte;
        end
    end

    lpmd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_move),
        .i_byte    (r_s1_byte),
        .o_res     (w_res)
    );

    lpmd_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_move),
        .i_res     (w_res),
        .i_stall   (i_stall),
        .o_blocked (w_blocked),
        .o_res     (w_out)
    );

    assign o_valid            = w_out.valid;
    assign o_payload_byte     = w_out.payload_byte;
    assign o_message_id       = w_out.message_id;
    assign o_first_of_message = w_out.first_of_message;
    assign o_last_of_message  = w_out.last_of_message;
    assign o_empty_message    = w_out.empty_message;

`ifndef ASSERT_OFF
    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && o_valid))
        else $error("input stalled with no byte held or no result waiting");

    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_s1_valid && r_s1_byte == $past(r_s1_byte)))
        else $error("stalled input byte lost or changed");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for length_prefixed_message_deframer_core: framed byte streams
// go in under random idle and stall, and every result is checked against a built-in model.
// Depends on lpmd_pkg and the deframer RTL only.

module testbench;
    import lpmd_pkg::*;

    // One expected fragment of a message, as the output channel shows it.
    typedef struct {
        logic [7:0]  data;
        logic [31:0] id;
        logic        first;
        logic        last;
        logic        empty;
    } t_frag;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_message_id;
    logic        o_first_of_message;
    logic        o_last_of_message;
    logic        o_empty_message;

    length_prefixed_message_deframer_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_in_byte          (i_in_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_payload_byte     (o_payload_byte),
        .o_message_id       (o_message_id),
        .o_first_of_message (o_first_of_message),
        .o_last_of_message  (o_last_of_message),
        .o_empty_message    (o_empty_message)
    );

    // Deframing state as the block should hold it, starting from its reset values.
    logic [3:0]  hdr_pos      = '0;
    logic [31:0] cur_len      = '0;
    logic [31:0] cur_id       = '0;
    logic [31:0] bytes_left   = '0;
    logic        in_body      = 1'b0;
    logic        body_started = 1'b0;

    logic [7:0] stream_bytes[$];    // bytes still to be offered to the block
    t_frag      expected_frags[$];  // fragments predicted but not yet seen

    int tx_idle_pct = 28;     // chance per cycle that the sender offers nothing
    int rx_idle_pct = 51;     // chance per cycle that the receiver stalls
    bit hold_tx     = 1'b0;   // when set, start no new request
    bit req_pending = 1'b0;   // a request is on the input channel, not yet taken
    int errors      = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the deframing state by one accepted stream byte and queue the
    // fragment it produces, if any.
    function automatic void track_stream_byte(input logic [7:0] b);
        t_frag      frag;
        logic [2:0] pos;
        if (in_body) begin
            // Payload byte: first mark until one has gone out, last on the final one.
            frag.data  = b;
            frag.id    = cur_id;
            frag.first = !body_started;
            frag.last  = (bytes_left <= 32'd1);
            frag.empty = 1'b0;
            expected_frags.insert(expected_frags.size(), frag);
            bytes_left   = bytes_left - 32'd1;
            body_started = 1'b1;
            if (frag.last) begin
                in_body      = 1'b0;
                body_started = 1'b0;
                bytes_left   = '0;
            end
        end else begin
            // Header byte: low four bytes build the length, high four the id,
            // both little-endian.
            pos = hdr_pos[2:0];
            if (pos < LENGTH_BYTES)
                cur_len[pos*8 +: 8] = b;
            else
                cur_id[(pos-LENGTH_BYTES)*8 +: 8] = b;
            if (pos != HEADER_BYTES - 1) begin
                hdr_pos = hdr_pos + 4'd1;
            end else begin
                hdr_pos = '0;
                if (cur_len == '0) begin
                    // Empty message: one fragment with every mark set, data zero.
                    frag.data  = 8'h00;
                    frag.id    = cur_id;
                    frag.first = 1'b1;
                    frag.last  = 1'b1;
                    frag.empty = 1'b1;
                    expected_frags.insert(expected_frags.size(), frag);
                end else begin
                    bytes_left   = cur_len;
                    in_body      = 1'b1;
                    body_started = 1'b0;
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: change inputs at the falling edge only. Hold a request until it is
    // taken; in between, idle at random or when told to hold off.
    always @(negedge i_clk) begin
        if (i_rst_n && !req_pending) begin
            if (!hold_tx && stream_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                i_valid     <= 1'b1;
                i_in_byte   <= stream_bytes.pop_front();
                req_pending  = 1'b1;
            end else begin
                i_valid   <= 1'b0;
                i_in_byte <= 8'($urandom);
            end
        end
    end

    // Receiver side: stall at random, never during reset.
    always @(negedge i_clk)
        i_stall <= i_rst_n && ($urandom_range(99) < rx_idle_pct);

    // Monitor: at the rising edge record what the block took, then check what
    // it handed out. Taking first keeps the order fixed within the edge.
    always @(posedge i_clk) begin : sampler
        t_frag want;
        if (i_rst_n && i_valid && !o_stall) begin
            track_stream_byte(i_in_byte);
            req_pending = 1'b0;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_frags.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual byte %h id %h",
                         $time, o_payload_byte, o_message_id);
                errors++;
            end else begin
                want = expected_frags.pop_front();
                check_field("payload_byte", 32'(want.data), 32'(o_payload_byte));
                check_field("message_id", want.id, o_message_id);
                check_field("first_of_message", 32'(want.first), 32'(o_first_of_message));
                check_field("last_of_message", 32'(want.last), 32'(o_last_of_message));
                check_field("empty_message", 32'(want.empty), 32'(o_empty_message));
            end
        end
    end

    // Step just past the rising edge so the monitor has already run.
    task automatic tick();
        @(posedge i_clk);
        #1;
    endtask

    task automatic add_header(input logic [31:0] len, input logic [31:0] id);
        int k;
        for (k = 0; k < 4; k++)
            stream_bytes.insert(stream_bytes.size(), len[k*8 +: 8]);
        for (k = 0; k < 4; k++)
            stream_bytes.insert(stream_bytes.size(), id[k*8 +: 8]);
    endtask

    task automatic add_random_bytes(input int count);
        int k;
        for (k = 0; k < count; k++)
            stream_bytes.insert(stream_bytes.size(), 8'($urandom));
    endtask

    // Queue whole messages of mostly short random length until about
    // target bytes are waiting.
    task automatic add_messages(input int target);
        int n;
        int pick;
        int len;
        n = 0;
        while (n < target) begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = 0;
            else if (pick < 25)
                len = 1;
            else if (pick < 85)
                len = $urandom_range(24, 2);
            else
                len = $urandom_range(300, 25);
            add_header(32'(len), $urandom);
            add_random_bytes(len);
            n += HEADER_BYTES + len;
        end
    endtask

    task automatic wait_sent();
        while (stream_bytes.size() > 0 || req_pending)
            tick();
    endtask

    // Hold off new requests until every predicted fragment has come out.
    task automatic wait_drained();
        hold_tx = 1'b1;
        while (req_pending || expected_frags.size() > 0)
            tick();
        hold_tx = 1'b0;
    endtask

    initial begin : stimulus
        int waited;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message with all-ones id, a single-byte payload of
        // 0xFF, then a two-byte payload of 0x00 and 0x80.
        add_header(32'd0, 32'hFFFF_FFFF);
        add_header(32'd1, 32'h0000_0000);
        stream_bytes.insert(stream_bytes.size(), 8'hFF);
        add_header(32'd2, 32'h8000_0001);
        stream_bytes.insert(stream_bytes.size(), 8'h00);
        stream_bytes.insert(stream_bytes.size(), 8'h80);

        // Sender idles less than the receiver stalls.
        add_messages(560);
        wait_sent();
        wait_drained();

        // Swap the idle rates; pause once mid-stream until the output is empty.
        tick();
        tx_idle_pct = 51;
        rx_idle_pct = 28;
        add_messages(300);
        while (stream_bytes.size() > 150)
            tick();
        wait_drained();
        add_messages(280);
        wait_sent();

        // Full rate both ways. Close with an all-ones length so the block
        // stays in payload for the rest of the run.
        tick();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_messages(420);
        add_header(32'hFFFF_FFFF, $urandom);
        add_random_bytes(150);
        wait_sent();

        waited = 0;
        while (expected_frags.size() > 0 && waited < 5000) begin
            tick();
            waited++;
        end
        repeat (8) tick();
        if (expected_frags.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_frags.size());
            errors += expected_frags.size();
        end
        if (errors == 0)
            $display("PASS length_prefixed_message_deframer_core");
        else
            $display("FAIL length_prefixed_message_deframer_core");
        $finish;
    end

    // Watchdog: drop the run if it hangs.
    initial begin
        #5_000_000;
        $display("FAIL length_prefixed_message_deframer_core");
        $finish;
    end

endmodule
